### rtl/core/text_to_integer_parser_assert.svh
// Assertion macros shared by the parser RTL.
// TTIP_ASSERT checks on every clock edge outside reset.
// TTIP_ASSERT_NORST checks on every clock edge, reset included.
`ifndef TEXT_TO_INTEGER_PARSER_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TTIP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("parser assertion failed");
`define TTIP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("parser assertion failed");
`else
`define TTIP_ASSERT(lbl, clk, rstn, prop)
`define TTIP_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

### rtl/core/ttip_pkg.sv
package ttip_pkg;

  // Default length of the character window after leading whitespace.
  localparam int unsigned MaxCharsDef = 64;

  // Configuration register indexes.
  localparam logic [1:0] CfgNumberBase  = 2'd0;
  localparam logic [1:0] CfgWidthSelect = 2'd1;
  localparam logic [1:0] CfgSignedMode  = 2'd2;

  // Characters with a special meaning.
  localparam logic [6:0] ClampCode = 7'd127;
  localparam logic [6:0] CharMinus = 7'h2d;
  localparam logic [4:0] NoDigit   = 5'd31;

  typedef enum logic [1:0] {
    PhaseSkip = 2'd0,
    PhaseRead = 2'd1,
    PhaseStop = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusNoDigits = 2'd2,
    StatusRange    = 2'd3
  } status_e;

  // Running parse state of one text.
  typedef struct packed {
    logic [63:0] acc;
    phase_e      phase;
    logic        minus;
    logic        ovf;
    logic        digit;
  } pstate_t;

  // Register settings seen by the character step.
  typedef struct packed {
    logic [4:0] number_base;
    logic [1:0] width_select;
    logic       signed_mode;
  } cfg_t;

  // Effective radix: anything other than 8 or 16 acts as 10.
  function automatic logic [4:0] radix(input logic [4:0] base);
    logic [4:0] r;
    if (base == 5'd8 || base == 5'd16) begin
      r = base;
    end else begin
      r = 5'd10;
    end
    return r;
  endfunction

  // Digit value of a clamped character, NoDigit when it is none.
  function automatic logic [4:0] digit_value(input logic [6:0] c);
    logic [4:0] d;
    d = NoDigit;
    if (c >= 7'h30 && c <= 7'h39) begin
      d = 5'(c - 7'h30);
    end else if (c >= 7'h61 && c <= 7'h66) begin
      d = 5'(c - 7'h57);
    end else if (c >= 7'h41 && c <= 7'h46) begin
      d = 5'(c - 7'h37);
    end
    return d;
  endfunction

  // Mask of the bits inside the selected result width.
  function automatic logic [63:0] width_mask(input logic [1:0] ws);
    logic [63:0] m;
    unique case (ws)
      2'd0: m = 64'h0000_0000_0000_00ff;
      2'd1: m = 64'h0000_0000_0000_ffff;
      2'd2: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // Largest magnitude allowed for width, mode and sign.
  function automatic logic [63:0] limit(input logic [1:0] ws, input logic sgn,
                                        input logic minus);
    logic [63:0] full;
    logic [63:0] half;
    logic [63:0] lim;
    full = width_mask(ws);
    half = (full >> 1) + 64'd1;
    if (!sgn) begin
      lim = full;
    end else if (minus) begin
      lim = half;
    end else begin
      lim = half - 64'd1;
    end
    return lim;
  endfunction

endpackage

### rtl/core/ttip_char_step.sv
// Applies one character to the running parse state: whitespace skip,
// window count, sign, digit decode and the range-checked accumulate.
module ttip_char_step import ttip_pkg::*; #(
  parameter int unsigned MaxChars = MaxCharsDef,
  localparam int unsigned WinW = $clog2(MaxChars + 1)
) (
  input  pstate_t           st_i,
  input  logic [WinW-1:0]   win_i,
  input  cfg_t              cfg_i,
  input  logic [20:0]       code_point_i,
  input  logic              no_character_i,
  output pstate_t           st_o,
  output logic [WinW-1:0]   win_o,
  output logic              over_o
);

  logic [6:0]  c7;
  logic [4:0]  d;
  logic [4:0]  b;
  logic        ws_char;
  logic [63:0] lim;
  logic [68:0] acc_x;
  logic [68:0] prod;
  logic        range_hi;
  logic        acc_upd;

  // Clamp, classify and decode the character.
  assign c7       = (code_point_i > 21'd127) ? ClampCode : code_point_i[6:0];
  assign ws_char  = (code_point_i == 21'd32) ||
                    (code_point_i >= 21'd9 && code_point_i <= 21'd13);
  assign d        = digit_value(c7);
  assign b        = radix(cfg_i.number_base);
  assign lim      = limit(cfg_i.width_select, cfg_i.signed_mode, st_i.minus);

  // Next magnitude, wide enough that it cannot wrap; the radix is a shift sum.
  assign acc_x = {5'd0, st_i.acc};
  always_comb begin
    unique case (b)
      5'd8:    prod = (acc_x << 3) + {64'd0, d};
      5'd16:   prod = (acc_x << 4) + {64'd0, d};
      default: prod = (acc_x << 3) + (acc_x << 1) + {64'd0, d};
    endcase
  end

  // Held magnitude already beyond the current range.
  assign range_hi = st_i.acc > lim;

  always_comb begin
    st_o    = st_i;
    win_o   = win_i;
    acc_upd = 1'b0;
    if (!no_character_i) begin
      if (st_i.phase == PhaseSkip && !ws_char) begin
        st_o.phase = PhaseRead;
      end
      if (st_o.phase == PhaseRead && win_i < WinW'(MaxChars)) begin
        win_o = win_i + WinW'(1);
        if (win_i == '0 && c7 == CharMinus && cfg_i.signed_mode) begin
          st_o.minus = 1'b1;
        end else if (d >= b) begin
          st_o.phase = PhaseStop;
        end else begin
          st_o.digit = 1'b1;
          if (!st_i.ovf) begin
            if (prod > {5'd0, lim}) begin
              st_o.ovf = 1'b1;
            end else begin
              st_o.acc = prod[63:0];
              acc_upd  = 1'b1;
            end
          end
        end
      end
    end
    // A fresh accumulate is within range; a kept magnitude uses the early compare.
    over_o = st_o.ovf || (!acc_upd && range_hi);
  end

endmodule

### rtl/core/text_to_integer_parser.sv
// Text to integer parser. Characters arrive one beat each on the slave
// stream (code point in tdata, tlast on the last character, tuser set for a
// beat that carries no character); the master stream gives one beat per
// text with the value in tdata and the status in tuser (0 ok, 1 empty,
// 2 no digits, 3 out of range). One character is taken every clock unless a
// beat that ends a text waits on a full result slot: a beat is registered,
// then applied to the parse state, where the radix multiply-add and the
// range compare form the longest path. A text's result is registered.
// Registers: 0 radix (8, 10 or 16), 1 width (8/16/32/64), 2 signed mode.
`include "text_to_integer_parser_assert.svh"

module text_to_integer_parser import ttip_pkg::*; #(
  parameter int unsigned MaxChars = MaxCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        s_axis_tlast,
  input  logic [0:0]  s_axis_tuser,   // [0] no_character
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] parsed_value
  output logic [1:0]  m_axis_tuser,   // [1:0] parse_status
  // Register writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned WinW = $clog2(MaxChars + 1);

  cfg_t            cfg_q;
  logic            in_valid_q;
  logic [20:0]     in_cp_q;
  logic            in_last_q;
  logic            in_none_q;
  pstate_t         st_q;
  pstate_t         st_d;
  logic [WinW-1:0] win_q;
  logic [WinW-1:0] win_d;
  logic            over;
  logic            proc_go;
  logic            out_valid_q;
  logic [63:0]     out_value_q;
  status_e         out_status_q;
  logic [63:0]     value_d;
  status_e         status_d;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_base  <= 5'd10;
      cfg_q.width_select <= 2'd2;
      cfg_q.signed_mode  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumberBase:  cfg_q.number_base  <= cfg_data_i;
        CfgWidthSelect: cfg_q.width_select <= cfg_data_i[1:0];
        CfgSignedMode:  cfg_q.signed_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The held beat moves on unless it ends a text and the result slot stays full.
  assign proc_go       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cp_q   <= s_axis_tdata[20:0];
      in_last_q <= s_axis_tlast;
      in_none_q <= s_axis_tuser[0];
    end
  end

  ttip_char_step #(
    .MaxChars (MaxChars)
  ) u_char_step (
    .st_i           (st_q),
    .win_i          (win_q),
    .cfg_i          (cfg_q),
    .code_point_i   (in_cp_q),
    .no_character_i (in_none_q),
    .st_o           (st_d),
    .win_o          (win_d),
    .over_o         (over)
  );

  // Parse state; cleared after the beat that ends a text.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{acc: '0, phase: PhaseSkip, minus: 1'b0, ovf: 1'b0, digit: 1'b0};
      win_q <= '0;
    end else if (proc_go) begin
      if (in_last_q) begin
        st_q  <= '{acc: '0, phase: PhaseSkip, minus: 1'b0, ovf: 1'b0, digit: 1'b0};
        win_q <= '0;
      end else begin
        st_q  <= st_d;
        win_q <= win_d;
      end
    end
  end

  // Final status and value of a text.
  always_comb begin
    value_d = '0;
    priority if (st_d.phase == PhaseSkip) begin
      status_d = StatusEmpty;
    end else if (!st_d.digit) begin
      status_d = StatusNoDigits;
    end else if (over) begin
      status_d = StatusRange;
    end else begin
      status_d = StatusOk;
      value_d  = (st_d.minus ? (64'd0 - st_d.acc) : st_d.acc) &
                 width_mask(cfg_q.width_select);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && in_last_q) begin
      out_value_q  <= value_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  `TTIP_ASSERT(a_err_value_zero, clk_i, rst_ni,
    (m_axis_tvalid && out_status_q != StatusOk) |-> (out_value_q == 64'd0))
  `TTIP_ASSERT(a_byte_width_clean, clk_i, rst_ni,
    (m_axis_tvalid && cfg_q.width_select == 2'd0) |-> (out_value_q[63:8] == 56'd0))
  `TTIP_ASSERT(a_clear_after_text, clk_i, rst_ni,
    (proc_go && in_last_q) |=> (st_q.phase == PhaseSkip && win_q == '0 && st_q.acc == '0))
  `TTIP_ASSERT(a_skip_is_clean, clk_i, rst_ni,
    (st_q.phase == PhaseSkip) |-> (!st_q.digit && !st_q.minus && win_q == '0))
  `TTIP_ASSERT(a_window_bound, clk_i, rst_ni,
    win_q <= WinW'(MaxChars))
  `TTIP_ASSERT_NORST(a_reset_clears, clk_i,
    (!rst_ni) |=> (!m_axis_tvalid && win_q == '0))

endmodule
